[hdl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes of the double-ended queue: opcodes, status codes,
// fixed field widths and the control state enum
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int OPCODE_W = 3;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam opcode_type OP_PUSH_BACK  = 3'd0;
   localparam opcode_type OP_PUSH_FRONT = 3'd1;
   localparam opcode_type OP_POP_BACK   = 3'd2;
   localparam opcode_type OP_POP_FRONT  = 3'd3;
   localparam opcode_type OP_NOP        = 3'd4;

   // result status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_POP_EMPTY = 2'd1;
   localparam status_type STATUS_PUSH_FULL = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

[hdl/dq_if.sv]
// ----------------------------------------------------------------------------
// dq request and response channels
// valid/ready channels carrying one operation and one result
// ----------------------------------------------------------------------------
interface dq_req_if;
   logic                 valid;
   logic                 ready;
   dq_pkg::opcode_type   opcode;
   dq_pkg::word_type     push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if;
   logic                 valid;
   logic                 ready;
   dq_pkg::word_type     popped_value;
   dq_pkg::word_type     front_value;
   dq_pkg::word_type     back_value;
   dq_pkg::count_type    element_count;
   logic                 is_empty;
   dq_pkg::status_type   status;

   modport source (output valid, output popped_value, output front_value,
                   output back_value, output element_count, output is_empty,
                   output status, input ready);
   modport sink (input valid, input popped_value, input front_value,
                 input back_value, input element_count, input is_empty,
                 input status, output ready);
endinterface

[hdl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// ring storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top
// fixed-capacity double-ended queue kept as a ring buffer in one memory
// ----------------------------------------------------------------------------
//
//   channel   direction  payload
//   req_if    in         opcode, push_value
//   rsp_if    out        popped_value, front_value, back_value,
//                        element_count, is_empty, status
//
// in each transaction the accept cycle updates head and count, writes a
// pushed word and issues the one memory read; the next cycle takes
// the read data (the new front or back after a pop) into the result register
// front and back words live in registers, so only a pop needs the memory read
// reset is synchronous; it empties the queue, no clearing pass is needed
// a new request is taken while the result register drains in the same cycle
// a stalled response holds the result and blocks further requests
//
module double_ended_queue_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   dq_req_if.sink   req_if,
   dq_rsp_if.source rsp_if
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   // control state
   dq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // cached end words and pending fix-up from the memory read
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in;
   dq_pkg::status_type    status_ff, status_in;
   logic                  fix_front_ff, fix_front_in;
   logic                  fix_back_ff, fix_back_in;

   // result register
   dq_pkg::word_type   rsp_popped_ff, rsp_popped_in;
   dq_pkg::word_type   rsp_front_ff, rsp_front_in;
   dq_pkg::word_type   rsp_back_ff, rsp_back_in;
   dq_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;
   dq_pkg::status_type rsp_status_ff, rsp_status_in;

   // handshake and slot arithmetic
   logic                  req_ready;
   logic                  accept;
   logic [DATA_WIDTH-1:0] word;
   logic [SW-1:0]         sum_tail, sum_prev, sum_inc;
   logic [AW-1:0]         tail_slot, prev_slot, head_inc, head_dec;
   logic                  is_full, is_none;

   // memory ports
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   dq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign word   = DATA_WIDTH'(req_if.push_value);
   assign accept = req_if.valid && req_ready;

   // ring slot arithmetic, sums stay below twice the depth
   always_comb begin
      sum_tail  = SW'(head_ff) + SW'(count_ff);
      tail_slot = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
      sum_prev  = sum_tail - SW'(2);
      prev_slot = (sum_prev >= SW'(DEPTH)) ? AW'(sum_prev - SW'(DEPTH)) : AW'(sum_prev);
      sum_inc   = SW'(head_ff) + SW'(1);
      head_inc  = (sum_inc >= SW'(DEPTH)) ? AW'(sum_inc - SW'(DEPTH)) : AW'(sum_inc);
      head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      is_full   = (count_ff == CW'(DEPTH));
      is_none   = (count_ff == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = dq_pkg::ST_READ;
            end
         end
         dq_pkg::ST_READ: begin
            state_in = dq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs: take a request only when the result register frees up
   always_comb begin
      req_ready = 1'b0;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_if.ready;
         end
         dq_pkg::ST_READ: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // operation datapath
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      fix_front_in = fix_front_ff;
      fix_back_in  = fix_back_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_slot;
      rd_en        = 1'b0;
      rd_addr      = prev_slot;

      if (accept) begin
         popped_in    = '0;
         status_in    = dq_pkg::STATUS_OK;
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;
         unique case (req_if.opcode)
            dq_pkg::OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_slot;
                  count_in = count_ff + CW'(1);
                  back_in  = word;
                  if (is_none) begin
                     front_in = word;
                  end
               end
            end
            dq_pkg::OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = dq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = word;
                  if (is_none) begin
                     back_in = word;
                  end
               end
            end
            dq_pkg::OP_POP_BACK: begin
               if (is_none) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  popped_in = back_ff;
                  count_in  = count_ff - CW'(1);
                  // new back sits one slot before the old one
                  rd_en       = 1'b1;
                  rd_addr     = prev_slot;
                  fix_back_in = (count_ff != CW'(1));
               end
            end
            dq_pkg::OP_POP_FRONT: begin
               if (is_none) begin
                  status_in = dq_pkg::STATUS_POP_EMPTY;
               end else begin
                  popped_in    = front_ff;
                  head_in      = head_inc;
                  count_in     = count_ff - CW'(1);
                  rd_en        = 1'b1;
                  rd_addr      = head_inc;
                  fix_front_in = (count_ff != CW'(1));
               end
            end
            default: begin
               // no operation, also for unused codes
            end
         endcase
      end else if (state_ff == dq_pkg::ST_READ) begin
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;
         if (fix_front_ff) begin
            front_in = rd_data;
         end
         if (fix_back_ff) begin
            back_in = rd_data;
         end
      end
   end

   // result register, loaded in the read cycle
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == dq_pkg::ST_READ) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = dq_pkg::word_type'(popped_ff);
         rsp_empty_in  = is_none;
         rsp_front_in  = is_none ? '0 : dq_pkg::word_type'(front_in);
         rsp_back_in   = is_none ? '0 : dq_pkg::word_type'(back_in);
         rsp_count_in  = dq_pkg::count_type'(count_ff);
         rsp_status_in = status_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fix_front_ff <= 1'b0;
         fix_back_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         fix_front_ff <= fix_front_in;
         fix_back_ff  <= fix_back_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.popped_value  = rsp_popped_ff;
   assign rsp_if.front_value   = rsp_front_ff;
   assign rsp_if.back_value    = rsp_back_ff;
   assign rsp_if.element_count = rsp_count_ff;
   assign rsp_if.is_empty      = rsp_empty_ff;
   assign rsp_if.status        = rsp_status_ff;

endmodule

[tb/sv/tb_double_ended_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// self-checking bench for the double-ended queue: a directed pass through
// empty, undefined-opcode and single-word cases, then random push/pop
// segments that fill the queue to capacity and drain it again, with
// both channels stalling at random
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH      = 64;
   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 3;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_ITEMS     = 1425;
   localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off that backs the block up
   localparam int HOLD_AT_RESULT   = 250;   // results seen before the hold-off starts
   localparam int FLUSH_AT_ITEM    = 900;   // random item at which the sender drains
   localparam int DRAIN_CYCLES     = 20;    // quiet cycles after the last result
   localparam int PATTERN_CYCLES   = 64;    // receiver keeps one stall pattern this long

   // operation mix of one random segment
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } op_mix_type;

   // receiver stall patterns
   typedef enum int {
      RX_STREAM,
      RX_MOSTLY,
      RX_SPARSE,
      RX_PERIODIC
   } rx_pattern_type;

   typedef struct {
      word_type   popped_value;
      word_type   front_value;
      word_type   back_value;
      count_type  element_count;
      logic       is_empty;
      status_type status;
   } deque_result_type;

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the ring buffer and keeps the results still owed
   // -------------------------------------------------------------------------
   class deque_scoreboard;
      word_type         ring_copy [QUEUE_DEPTH];
      int               head_slot;
      int               word_count;
      deque_result_type pending_results [$];
      int               error_count;

      function new();
         head_slot   = 0;
         word_count  = 0;
         error_count = 0;
      endfunction

      function int slot_at(int offset);
         return (head_slot + offset) % QUEUE_DEPTH;
      endfunction

      // apply one accepted operation to the mirror and queue its result
      function void note_operation(opcode_type opcode, word_type push_value);
         deque_result_type want;
         want.popped_value = '0;
         want.status       = STATUS_OK;
         case (opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (word_count == QUEUE_DEPTH) begin
                  want.status = STATUS_PUSH_FULL;
               end else if (opcode == OP_PUSH_BACK) begin
                  ring_copy[slot_at(word_count)] = push_value;
                  word_count++;
               end else begin
                  head_slot = slot_at(QUEUE_DEPTH - 1);
                  ring_copy[head_slot] = push_value;
                  word_count++;
               end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
               if (word_count == 0) begin
                  want.status = STATUS_POP_EMPTY;
               end else if (opcode == OP_POP_BACK) begin
                  want.popped_value = ring_copy[slot_at(word_count - 1)];
                  word_count--;
               end else begin
                  want.popped_value = ring_copy[head_slot];
                  head_slot = slot_at(1);
                  word_count--;
               end
            end
            default: ;   // no-op and undefined codes leave the state alone
         endcase
         want.element_count = count_type'(word_count);
         want.is_empty      = (word_count == 0);
         want.front_value   = (word_count != 0) ? ring_copy[head_slot] : '0;
         want.back_value    = (word_count != 0) ? ring_copy[slot_at(word_count - 1)] : '0;
         pending_results.insert(pending_results.size(), want);
      endfunction

      function void report_field(string field_name, logic [WORD_W-1:0] want_value,
                                 logic [WORD_W-1:0] got_value);
         if (got_value !== want_value) begin
            $display("%0t: %s expected %0h, got %0h", $time, field_name,
                     want_value, got_value);
            error_count++;
         end
      endfunction

      // compare one result transaction with the oldest expectation
      function void check_result(deque_result_type got);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result expected none, got popped %0h count %0d status %0d",
                     $time, got.popped_value, got.element_count, got.status);
            error_count++;
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         report_field("popped_value",  want.popped_value,  got.popped_value);
         report_field("front_value",   want.front_value,   got.front_value);
         report_field("back_value",    want.back_value,    got.back_value);
         report_field("element_count", want.element_count, got.element_count);
         report_field("is_empty",      want.is_empty,      got.is_empty);
         report_field("status",        want.status,        got.status);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, channels and the block itself
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   dq_req_if req_if ();
   dq_rsp_if rsp_if ();

   double_ended_queue_top #(
      .DEPTH      (QUEUE_DEPTH),
      .DATA_WIDTH (WORD_W)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   deque_scoreboard scoreboard = new();

   int             cycle_count  = 0;
   int             results_seen = 0;
   int             burst_left   = 0;
   bit             gaps_on      = 1'b1;
   int             hold_left    = 0;
   bit             hold_done    = 1'b0;
   int             pattern_left = 0;
   rx_pattern_type rx_pattern   = RX_STREAM;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // receiver: ready changes on the falling edge
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      // one long hold-off once the run is well under way, so the block
      // backs up and has to drop req ready while the sender keeps offering
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_done = 1'b1;
      end
      // pick a fresh stall pattern every so often
      if (pattern_left == 0) begin
         rx_pattern   = rx_pattern_type'($urandom_range(RX_STREAM, RX_PERIODIC));
         pattern_left = PATTERN_CYCLES;
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_STREAM:   rsp_if.ready <= 1'b1;
            RX_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_if.ready <= (cycle_count[1:0] != 2'b00);
         endcase
      end
   end

   // result transactions are taken at the rising edge
   always @(posedge clock) begin
      deque_result_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.popped_value  = rsp_if.popped_value;
         got.front_value   = rsp_if.front_value;
         got.back_value    = rsp_if.back_value;
         got.element_count = rsp_if.element_count;
         got.is_empty      = rsp_if.is_empty;
         got.status        = rsp_if.status;
         scoreboard.check_result(got);
         results_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // sender
   // -------------------------------------------------------------------------

   // offer one operation and wait for the handshake; when gaps are on, a burst
   // that has run out is followed by a short random gap
   task automatic send_operation(opcode_type opcode, word_type push_value);
      if (gaps_on && burst_left == 0) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.opcode     <= opcode;
      req_if.push_value <= push_value;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      scoreboard.note_operation(opcode, push_value);
      if (burst_left > 0) burst_left--;
   endtask

   // stop offering and wait until every owed result has come back
   task automatic settle_queue();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
   endtask

   // random operation under a given mix; a few no-ops and undefined codes
   function automatic opcode_type pick_operation(op_mix_type mix);
      int roll;
      int push_share;
      roll       = $urandom_range(0, 99);
      push_share = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 47;
      if (roll < 5)
         return opcode_type'($urandom_range(OP_NOP, (1 << OPCODE_W) - 1));
      else if (roll < 5 + push_share)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
         return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   initial begin
      int         sent;
      int         seg_len;
      op_mix_type mix;

      req_if.valid      = 1'b0;
      req_if.opcode     = OP_NOP;
      req_if.push_value = '0;
      rsp_if.ready      = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: queries and pops on an empty queue, undefined codes
      send_operation(OP_NOP, $urandom);
      send_operation(OP_POP_BACK, $urandom);
      send_operation(OP_POP_FRONT, $urandom);
      for (int code = OP_NOP + 1; code < (1 << OPCODE_W); code++)
         send_operation(opcode_type'(code), $urandom);

      // extremes of the data word at both ends
      send_operation(OP_PUSH_BACK, '1);
      send_operation(OP_PUSH_FRONT, '0);
      send_operation(OP_PUSH_BACK, 32'hA5A5_A5A5);
      send_operation(OP_PUSH_FRONT, 32'h5A5A_5A5A);
      send_operation(OP_NOP, $urandom);
      send_operation(opcode_type'(OP_NOP + 1), $urandom);

      // pop down to empty from both ends, then once more past empty
      send_operation(OP_POP_FRONT, $urandom);
      send_operation(OP_POP_BACK, $urandom);
      send_operation(OP_POP_BACK, $urandom);
      send_operation(OP_POP_FRONT, $urandom);
      send_operation(OP_POP_FRONT, $urandom);

      // single word pushed at one end and popped at the other
      send_operation(OP_PUSH_FRONT, 32'h0000_0001);
      send_operation(OP_POP_BACK, $urandom);
      send_operation(OP_PUSH_BACK, 32'h8000_0000);
      send_operation(OP_POP_FRONT, $urandom);

      // random segments; the first one fills the queue past capacity
      sent = 0;
      mix  = MIX_FILL;
      seg_len = 120;
      while (sent < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (seg_len) begin
            if (sent < RANDOM_ITEMS) begin
               // one full drain mid-run
               if (sent == FLUSH_AT_ITEM) settle_queue();
               send_operation(pick_operation(mix), $urandom);
               sent++;
            end
         end
         mix     = op_mix_type'($urandom_range(MIX_FILL, MIX_EVEN));
         seg_len = $urandom_range(40, 120);
      end

      settle_queue();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_ram.sv
hdl/double_ended_queue_top.sv
tb/sv/tb_double_ended_queue_top.sv
